/* hw/rtl/edge_period_tachometer_assert.svh */
// ----------------------------------------------------------------------------
// Tachometer assertion macros
// Concurrent assertion helpers, clocked by clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef EDGE_PERIOD_TACHOMETER_ASSERT_SVH
`define EDGE_PERIOD_TACHOMETER_ASSERT_SVH
`ifndef SYNTH
`define ETACH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ETACH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);
`else
`define ETACH_ASSERT(lbl, prop, msg)
`define ETACH_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* hw/rtl/etach_pkg.sv */
// ----------------------------------------------------------------------------
// Tachometer package
// Shared widths, register codes, reset values and the queue tag type.
// ----------------------------------------------------------------------------
`default_nettype none

package etach_pkg;

	localparam int SPAN_W      = 17;
	localparam int RATE_W      = 20;
	localparam int REV_W       = 20;
	localparam int ELAPSED_W   = 24;
	localparam int DIV_CNT_W   = $clog2(RATE_W + 1);
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [SPAN_W-1:0]    SPAN_RESET  = 17'd65535;
	localparam logic [RATE_W-1:0]    RATE_RESET  = 20'd62500;
	localparam logic [REV_W-1:0]     REV_MAX     = 20'd1000000;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 24'hFFFFFF;

	// Register index, taken from paddr[2].
	localparam logic REG_SPAN = 1'b0;
	localparam logic REG_RATE = 1'b1;

	// Input operation codes.
	localparam logic OP_OVERFLOW = 1'b0;
	localparam logic OP_EDGE     = 1'b1;

	// Control part of a queued measurement.
	typedef struct packed {
		logic channel;
		logic ovf_sat;
	} meas_tag_t;

endpackage

`default_nettype wire

/* hw/rtl/etach_front.sv */
// ----------------------------------------------------------------------------
// Tachometer front end
// Accepts events, keeps per-channel capture and overflow state, and queues
// every measuring edge with a snapshot of its channel state.
// ----------------------------------------------------------------------------
`default_nettype none

module etach_front #(
	parameter int CHANNELS      = 2,
	parameter int CAPTURE_BITS  = 16,
	parameter int OVERFLOW_BITS = 8
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_ready,
	input  wire                      operation,
	input  wire                      channel,
	input  wire  [CAPTURE_BITS-1:0]  capture,
	input  wire                      q_full,
	output logic                     push,
	output etach_pkg::meas_tag_t     push_tag,
	output logic [OVERFLOW_BITS-1:0] push_ovf,
	output logic [CAPTURE_BITS-1:0]  push_last,
	output logic [CAPTURE_BITS-1:0]  push_cap
);
	import etach_pkg::*;

	localparam logic [OVERFLOW_BITS-1:0] OVF_MAX = {OVERFLOW_BITS{1'b1}};

	logic [CAPTURE_BITS-1:0]  last_q [CHANNELS];
	logic [OVERFLOW_BITS-1:0] ovf_q  [CHANNELS];
	logic [CHANNELS-1:0]      seen_q;
	logic [CHANNELS-1:0]      hit;
	logic                     accept;
	logic                     is_edge;
	logic [CAPTURE_BITS-1:0]  sel_last;
	logic [OVERFLOW_BITS-1:0] sel_ovf;
	logic                     sel_seen;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign is_edge  = (operation == OP_EDGE);

	// An edge on a channel the block does not have matches nothing.
	always_comb begin
		hit      = '0;
		sel_last = '0;
		sel_ovf  = '0;
		sel_seen = 1'b0;
		for (int c = 0; c < CHANNELS; c++) begin
			if (32'(channel) == c) begin
				hit[c]   = 1'b1;
				sel_last = last_q[c];
				sel_ovf  = ovf_q[c];
				sel_seen = seen_q[c];
			end
		end
	end

	assign push              = accept && is_edge && sel_seen;
	assign push_tag.channel  = channel;
	assign push_tag.ovf_sat  = (sel_ovf == OVF_MAX);
	assign push_ovf          = sel_ovf;
	assign push_last         = sel_last;
	assign push_cap          = capture;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			for (int c = 0; c < CHANNELS; c++) begin
				ovf_q[c]  <= '0;
				last_q[c] <= '0;
			end
		end else if (accept) begin
			for (int c = 0; c < CHANNELS; c++) begin
				if (!is_edge) begin
					if (ovf_q[c] != OVF_MAX) begin
						ovf_q[c] <= ovf_q[c] + 1'b1;
					end
				end else if (hit[c]) begin
					seen_q[c] <= 1'b1;
					last_q[c] <= capture;
					ovf_q[c]  <= '0;
				end
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/etach_fifo.sv */
// ----------------------------------------------------------------------------
// Tachometer measurement queue
// Small register FIFO between the front end and the arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none

module etach_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  wire  [WIDTH-1:0] wdata,
	input  wire              pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);
	import etach_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`include "edge_period_tachometer_assert.svh"
	`ETACH_ASSERT(a_no_push_full, push |-> !full, "push into a full queue")
	`ETACH_ASSERT(a_no_pop_empty, pop |-> !empty, "pop from an empty queue")
	`ETACH_ASSERT(a_count_range, count_q <= CNT_W'(DEPTH), "queue count out of range")

endmodule

`default_nettype wire

/* hw/rtl/etach_back.sv */
// ----------------------------------------------------------------------------
// Tachometer back end
// Forms the elapsed tick count, divides the rate numerator by it one quotient
// bit per cycle and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module etach_back #(
	parameter int CAPTURE_BITS  = 16,
	parameter int OVERFLOW_BITS = 8
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire  [etach_pkg::SPAN_W-1:0]        counter_span,
	input  wire  [etach_pkg::RATE_W-1:0]        rate_numerator,
	input  wire                                 q_empty,
	output logic                                pop,
	input  wire  etach_pkg::meas_tag_t          pop_tag,
	input  wire  [OVERFLOW_BITS-1:0]            pop_ovf,
	input  wire  [CAPTURE_BITS-1:0]             pop_last,
	input  wire  [CAPTURE_BITS-1:0]             pop_cap,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic                                result_channel,
	output logic [etach_pkg::REV_W-1:0]         revolutions,
	output logic [etach_pkg::ELAPSED_W-1:0]     elapsed_ticks,
	output logic                                saturated
);
	import etach_pkg::*;

	localparam int PROD_W = OVERFLOW_BITS + SPAN_W;
	localparam int MAX_AB = (PROD_W > CAPTURE_BITS) ? PROD_W : CAPTURE_BITS;
	localparam int TOT_W  = ((MAX_AB > ELAPSED_W) ? MAX_AB : ELAPSED_W) + 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_SUB  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_RND  = 3'd4;
	localparam logic [2:0] ST_HOLD = 3'd5;

	logic [2:0]               state_q;
	logic                     ch_q;
	logic                     sat_q;
	logic [OVERFLOW_BITS-1:0] ovf_q;
	logic [CAPTURE_BITS-1:0]  last_q;
	logic [CAPTURE_BITS-1:0]  cap_q;
	logic [PROD_W-1:0]        prod_q;
	logic [ELAPSED_W-1:0]     elapsed_q;
	logic [ELAPSED_W-1:0]     rem_q;
	logic [RATE_W-1:0]        quo_q;
	logic [DIV_CNT_W-1:0]     div_cnt_q;
	logic [REV_W-1:0]         rev_q;

	logic                     out_valid_q;
	logic                     out_ch_q;
	logic [REV_W-1:0]         out_rev_q;
	logic [ELAPSED_W-1:0]     out_elapsed_q;
	logic                     out_sat_q;

	logic [TOT_W-1:0]         total;
	logic [TOT_W-1:0]         diff;
	logic                     behind;
	logic                     too_big;
	logic [ELAPSED_W:0]       rem_sh;
	logic [ELAPSED_W:0]       rem_sub;
	logic                     rem_ge;
	logic [REV_W:0]           quo_up;
	logic                     load_out;

	assign pop = (state_q == ST_IDLE) && !q_empty;

	// Elapsed ticks: overflows times span plus capture, less the previous capture.
	assign total   = TOT_W'(prod_q) + TOT_W'(cap_q);
	assign behind  = total < TOT_W'(last_q);
	assign diff    = total - TOT_W'(last_q);
	assign too_big = diff > TOT_W'(ELAPSED_MAX);

	// Restoring division step.
	assign rem_sh  = {rem_q, quo_q[RATE_W-1]};
	assign rem_ge  = rem_sh >= {1'b0, elapsed_q};
	assign rem_sub = rem_sh - {1'b0, elapsed_q};

	// Round the quotient up when a remainder is left.
	assign quo_up  = {1'b0, quo_q} + (REV_W + 1)'(rem_q != '0);

	assign load_out = (state_q == ST_HOLD) && (!out_valid_q || out_ready);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ch_q   <= pop_tag.channel;
				sat_q  <= pop_tag.ovf_sat;
				ovf_q  <= pop_ovf;
				last_q <= pop_last;
				cap_q  <= pop_cap;
			end
			ST_MUL: begin
				prod_q <= PROD_W'(ovf_q * counter_span);
			end
			ST_SUB: begin
				rem_q <= '0;
				quo_q <= rate_numerator;
				if (behind) begin
					elapsed_q <= '0;
				end else if (too_big) begin
					elapsed_q <= ELAPSED_MAX;
				end else begin
					elapsed_q <= diff[ELAPSED_W-1:0];
				end
				if (behind || diff == '0) begin
					rev_q <= REV_MAX;
					sat_q <= 1'b1;
				end else if (too_big) begin
					sat_q <= 1'b1;
				end
			end
			ST_DIV: begin
				rem_q <= rem_ge ? rem_sub[ELAPSED_W-1:0] : rem_sh[ELAPSED_W-1:0];
				quo_q <= {quo_q[RATE_W-2:0], rem_ge};
			end
			ST_RND: begin
				if (quo_up > (REV_W + 1)'(REV_MAX)) begin
					rev_q <= REV_MAX;
					sat_q <= 1'b1;
				end else begin
					rev_q <= quo_up[REV_W-1:0];
				end
			end
			default: begin
			end
		endcase
		if (load_out) begin
			out_ch_q      <= ch_q;
			out_rev_q     <= rev_q;
			out_elapsed_q <= elapsed_q;
			out_sat_q     <= sat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_SUB;
				end
				ST_SUB: begin
					div_cnt_q <= DIV_CNT_W'(RATE_W);
					if (behind || diff == '0) begin
						state_q <= ST_HOLD;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == DIV_CNT_W'(1)) begin
						state_q <= ST_RND;
					end
				end
				ST_RND: begin
					state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign result_channel = out_ch_q;
	assign revolutions    = out_rev_q;
	assign elapsed_ticks  = out_elapsed_q;
	assign saturated      = out_sat_q;

`include "edge_period_tachometer_assert.svh"
	`ETACH_ASSERT(a_div_count, (state_q == ST_DIV) |-> (div_cnt_q != '0), "divider overrun")
	`ETACH_ASSERT(a_exact_nonzero, (out_valid_q && !out_sat_q) |-> (out_elapsed_q != '0), "exact zero period")
	`ETACH_ASSERT_NEXT(a_hold_loads, load_out, out_valid_q, "result load did not raise valid")

endmodule

`default_nettype wire

/* hw/rtl/edge_period_tachometer.sv */
// Path: a measuring edge passes queue pop, multiply, subtract, the divider steps, round
//   and load to the output register; a zero or backward period skips the divider.
// Measuring edges: the back end works on one at a time with the one-bit-per-cycle divider
//   while later ones wait in the queue; overflow and first-edge items give no result.
// Reset: arst_n clears channel state, queue and output valid; registers take defaults.
// ----------------------------------------------------------------------------
// Edge period tachometer
// Multi-channel wheel speed measurement from the period between sensor edges.
// ----------------------------------------------------------------------------
`default_nettype none

module edge_period_tachometer #(
	parameter int CHANNELS      = 2,
	parameter int CAPTURE_BITS  = 16,
	parameter int OVERFLOW_BITS = 8
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// Configuration port.
	input  wire                                 psel,
	input  wire                                 penable,
	input  wire                                 pwrite,
	input  wire  [etach_pkg::PADDR_W-1:0]       paddr,
	input  wire  [etach_pkg::PDATA_W-1:0]       pwdata,
	output logic [etach_pkg::PDATA_W-1:0]       prdata,
	output logic                                pready,
	// Event input.
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire                                 operation,
	input  wire                                 channel,
	input  wire  [CAPTURE_BITS-1:0]             capture,
	// Measurement output.
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic                                result_channel,
	output logic [etach_pkg::REV_W-1:0]         revolutions,
	output logic [etach_pkg::ELAPSED_W-1:0]     elapsed_ticks,
	output logic                                saturated
);
	import etach_pkg::*;

	// One queue entry: tag, overflow snapshot, previous capture, new capture.
	localparam int Q_W = $bits(meas_tag_t) + OVERFLOW_BITS + 2 * CAPTURE_BITS;

	logic [SPAN_W-1:0]        span_q;
	logic [RATE_W-1:0]        rate_q;
	logic                     cfg_wr;

	logic                     q_full;
	logic                     q_empty;
	logic                     push;
	logic                     pop;
	meas_tag_t                push_tag;
	logic [OVERFLOW_BITS-1:0] push_ovf;
	logic [CAPTURE_BITS-1:0]  push_last;
	logic [CAPTURE_BITS-1:0]  push_cap;
	logic [Q_W-1:0]           q_wdata;
	logic [Q_W-1:0]           q_rdata;
	meas_tag_t                pop_tag;
	logic [OVERFLOW_BITS-1:0] pop_ovf;
	logic [CAPTURE_BITS-1:0]  pop_last;
	logic [CAPTURE_BITS-1:0]  pop_cap;

	// The port never stretches a transfer. Only paddr[2] picks the register,
	// so each register answers at every byte of its word.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q <= SPAN_RESET;
			rate_q <= RATE_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_SPAN: span_q <= pwdata[SPAN_W-1:0];
				REG_RATE: rate_q <= pwdata[RATE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_SPAN: prdata = PDATA_W'(span_q);
			REG_RATE: prdata = PDATA_W'(rate_q);
			default:  prdata = '0;
		endcase
	end

	// The front end updates channel state at each transfer; overflow and first-edge
	// items stall only while the queue is full, and only measuring edges queue.
	etach_front #(
		.CHANNELS      (CHANNELS),
		.CAPTURE_BITS  (CAPTURE_BITS),
		.OVERFLOW_BITS (OVERFLOW_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.channel   (channel),
		.capture   (capture),
		.q_full    (q_full),
		.push      (push),
		.push_tag  (push_tag),
		.push_ovf  (push_ovf),
		.push_last (push_last),
		.push_cap  (push_cap)
	);

	assign q_wdata = {push_tag, push_ovf, push_last, push_cap};

	etach_fifo #(
		.WIDTH (Q_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (q_wdata),
		.pop    (pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	assign {pop_tag, pop_ovf, pop_last, pop_cap} = q_rdata;

	// The back end holds its finished result in an output register, so it
	// can take the next queued edge as soon as the result is loaded there.
	etach_back #(
		.CAPTURE_BITS  (CAPTURE_BITS),
		.OVERFLOW_BITS (OVERFLOW_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.counter_span   (span_q),
		.rate_numerator (rate_q),
		.q_empty        (q_empty),
		.pop            (pop),
		.pop_tag        (pop_tag),
		.pop_ovf        (pop_ovf),
		.pop_last       (pop_last),
		.pop_cap        (pop_cap),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_channel (result_channel),
		.revolutions    (revolutions),
		.elapsed_ticks  (elapsed_ticks),
		.saturated      (saturated)
	);

endmodule

`default_nettype wire

/* sim/edge_period_tachometer_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge period tachometer testbench
// Sends timebase overflows and sensor edges through the valid/ready input,
// predicts each period measurement in the bench, and checks every transfer on
// the output in order. Register writes go through the APB port while the block
// is idle, over default, extreme and random settings.
// ----------------------------------------------------------------------------

module edge_period_tachometer_test;

	import etach_pkg::*;

	localparam int          CAP_W         = 16;
	localparam int          NUM_CH        = 2;
	localparam logic [7:0]  OVF_LIMIT     = 8'hFF;
	// Settle after the last predicted measurement before touching a register or
	// ending the run.
	localparam int          SETTLE_CYCLES = 60;

	// One period measurement as the block reports it.
	typedef struct packed {
		logic                 ch;
		logic [REV_W-1:0]     revs;
		logic [ELAPSED_W-1:0] elapsed;
		logic                 sat;
	} speed_t;

	logic                   clk            = 1'b0;
	logic                   arst_n         = 1'b0;
	logic                   psel           = 1'b0;
	logic                   penable        = 1'b0;
	logic                   pwrite         = 1'b0;
	logic [PADDR_W-1:0]     paddr          = '0;
	logic [PDATA_W-1:0]     pwdata         = '0;
	logic [PDATA_W-1:0]     prdata;
	logic                   pready;
	logic                   in_valid       = 1'b0;
	logic                   in_ready;
	logic                   operation      = OP_OVERFLOW;
	logic                   channel        = 1'b0;
	logic [CAP_W-1:0]       capture        = '0;
	logic                   out_valid;
	logic                   out_ready      = 1'b0;
	logic                   result_channel;
	logic [REV_W-1:0]       revolutions;
	logic [ELAPSED_W-1:0]   elapsed_ticks;
	logic                   saturated;

	// Bench copy of the block's registers and per-channel period state.
	logic [SPAN_W-1:0]      span_cfg       = SPAN_RESET;
	logic [RATE_W-1:0]      rate_cfg       = RATE_RESET;
	bit   [CAP_W-1:0]       last_cap [NUM_CH];
	bit   [7:0]             ovf_count [NUM_CH];
	bit                     edge_seen [NUM_CH];

	// Measurements predicted at input transfer, oldest first.
	speed_t                 pending_speeds [$];

	// Percentage of cycles in which each side holds off.
	int                     idle_pct       = 30;
	int                     mismatches     = 0;
	int                     events_sent    = 0;
	int                     speeds_checked = 0;
	int                     reg_writes     = 0;

	edge_period_tachometer u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.channel        (channel),
		.capture        (capture),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_channel (result_channel),
		.revolutions    (revolutions),
		.elapsed_ticks  (elapsed_ticks),
		.saturated      (saturated)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// A hung handshake or a lost result ends up here.
	initial begin
		#8_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic void log_failure(input string text);
		mismatches++;
		if (mismatches <= 10)
			$display("%t: %s", $realtime, text);
	endfunction

	// Advances the period state by one event. Overflows age every channel; the
	// first edge on a channel only anchors its period; every later edge closes
	// the period and yields one measurement.
	function automatic bit predict_speed(input logic op, input logic ch,
			input logic [CAP_W-1:0] cap, output speed_t m);
		longint unsigned total;
		longint unsigned ticks;
		longint unsigned revs;
		bit              sat;
		m = '0;
		if (op == OP_OVERFLOW) begin
			for (int c = 0; c < NUM_CH; c++)
				if (ovf_count[c] != OVF_LIMIT)
					ovf_count[c] = ovf_count[c] + 8'd1;
			return 1'b0;
		end
		if (!edge_seen[ch]) begin
			// Overflows before the first edge belong to no period.
			edge_seen[ch] = 1'b1;
			last_cap[ch]  = cap;
			ovf_count[ch] = '0;
			return 1'b0;
		end
		// A pinned overflow count means the true period is unknown.
		sat   = (ovf_count[ch] == OVF_LIMIT);
		total = 64'(ovf_count[ch]) * 64'(span_cfg) + 64'(cap);
		// A capture behind the previous one with too few overflows reads as zero.
		ticks = (total < 64'(last_cap[ch])) ? 64'd0 : total - 64'(last_cap[ch]);
		if (ticks > 64'(ELAPSED_MAX)) begin
			ticks = 64'(ELAPSED_MAX);
			sat   = 1'b1;
		end
		if (ticks == 64'd0) begin
			revs = 64'(REV_MAX);
			sat  = 1'b1;
		end else begin
			revs = (64'(rate_cfg) + ticks - 64'd1) / ticks;
			if (revs > 64'(REV_MAX)) begin
				revs = 64'(REV_MAX);
				sat  = 1'b1;
			end
		end
		last_cap[ch]  = cap;
		ovf_count[ch] = '0;
		m.ch      = ch;
		m.revs    = revs[REV_W-1:0];
		m.elapsed = ticks[ELAPSED_W-1:0];
		m.sat     = sat;
		return 1'b1;
	endfunction

	// Output side: checks each result transfer against the oldest prediction and
	// then decides whether to stall the next cycle. out_ready is sampled here
	// before its new value lands, so the check sees the value the block saw.
	always @(posedge clk) begin
		speed_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_speeds.size() == 0) begin
				log_failure($sformatf("measurement on channel %0d with none pending",
					result_channel));
			end else begin
				want = pending_speeds.pop_front();
				speeds_checked++;
				if (result_channel !== want.ch)
					log_failure($sformatf("result_channel: expected %0d, got %0d",
						want.ch, result_channel));
				if (revolutions !== want.revs)
					log_failure($sformatf("revolutions (ch %0d): expected %0d, got %0d",
						want.ch, want.revs, revolutions));
				if (elapsed_ticks !== want.elapsed)
					log_failure($sformatf("elapsed_ticks (ch %0d): expected %0d, got %0d",
						want.ch, want.elapsed, elapsed_ticks));
				if (saturated !== want.sat)
					log_failure($sformatf("saturated (ch %0d): expected %0d, got %0d",
						want.ch, want.sat, saturated));
			end
		end
		out_ready <= ($urandom_range(99) >= idle_pct);
	end

	// Presents one event and holds it until the transfer. Returns at the edge of
	// the transfer with in_valid still high, so back-to-back events never lower
	// and raise valid in the same step. While holding off, the payload wanders.
	task automatic send_event(input logic op, input logic ch, input logic [CAP_W-1:0] cap);
		speed_t m;
		while ($urandom_range(99) < idle_pct) begin
			in_valid  <= 1'b0;
			operation <= $urandom_range(1);
			channel   <= $urandom_range(1);
			capture   <= $urandom_range(16'hFFFF);
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		channel   <= ch;
		capture   <= cap;
		do
			@(posedge clk);
		while (!in_ready);
		events_sent++;
		if (predict_speed(op, ch, cap, m))
			pending_speeds.push_back(m);
	endtask

	// Stops the input, lets every predicted measurement arrive, then gives the
	// back end time to finish anything that carries no result.
	task automatic settle_block();
		in_valid <= 1'b0;
		while (pending_speeds.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One APB access. A write is followed by a read of the same register, and
	// every read is compared with the bench copy.
	task automatic access_reg(input logic idx, input bit do_write, input logic [31:0] value);
		logic [31:0] want;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= do_write;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		if (do_write) begin
			@(posedge clk);
			// The register takes the value at this edge.
			if (idx == REG_SPAN)
				span_cfg = value[SPAN_W-1:0];
			else
				rate_cfg = value[RATE_W-1:0];
			reg_writes++;
			penable <= 1'b0;
			pwrite  <= 1'b0;
			@(posedge clk);
			penable <= 1'b1;
		end
		@(posedge clk);
		want = (idx == REG_SPAN) ? 32'(span_cfg) : 32'(rate_cfg);
		if (prdata !== want)
			log_failure($sformatf("register %0d read %0h, expected %0h", idx, prdata, want));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [31:0] span, input logic [31:0] rate);
		settle_block();
		access_reg(REG_SPAN, 1'b1, span);
		access_reg(REG_RATE, 1'b1, rate);
	endtask

	// Random wheel traffic. Most of it follows one free-running timebase, so the
	// overflows and captures agree and the periods are real; the rest is stray
	// overflows and edges at random captures.
	task automatic drive_wheel_traffic(input int budget);
		int          sent;
		int unsigned tick;
		int unsigned delta;
		int unsigned span;
		int          pick;
		span = span_cfg;
		sent = 0;
		tick = $urandom_range(span - 1);
		while (sent < budget) begin
			pick = $urandom_range(99);
			if (pick < 80) begin
				case ($urandom_range(3))
					0: begin
						delta = $urandom_range(16);
					end
					1: begin
						delta = $urandom_range(span, 1);
					end
					2: begin
						delta = $urandom_range(3 * span, span);
					end
					default: begin
						delta = $urandom_range(255, 1);
					end
				endcase
				tick += delta;
				while (tick >= span) begin
					tick -= span;
					send_event(OP_OVERFLOW, $urandom_range(1), $urandom_range(16'hFFFF));
					sent++;
				end
				send_event(OP_EDGE, $urandom_range(1), tick[CAP_W-1:0]);
			end else if (pick < 90) begin
				send_event(OP_OVERFLOW, $urandom_range(1), $urandom_range(16'hFFFF));
			end else begin
				send_event(OP_EDGE, $urandom_range(1), $urandom_range(16'hFFFF));
			end
			sent++;
		end
	endtask

	task automatic test_register_defaults();
		access_reg(REG_SPAN, 1'b0, '0);
		access_reg(REG_RATE, 1'b0, '0);
	endtask

	// Default settings: first edges, zero and backward periods, captures at
	// both ends of their range, and overflows with every ignored bit set.
	task automatic test_directed_events();
		send_event(OP_EDGE,     1'b0, 16'd100);
		send_event(OP_EDGE,     1'b0, 16'd100);
		send_event(OP_EDGE,     1'b0, 16'd50);
		send_event(OP_OVERFLOW, 1'b1, 16'hFFFF);
		send_event(OP_EDGE,     1'b0, 16'hFFFF);
		send_event(OP_EDGE,     1'b1, 16'h0000);
		send_event(OP_OVERFLOW, 1'b0, 16'h0000);
		send_event(OP_EDGE,     1'b1, 16'hFFFF);
		send_event(OP_EDGE,     1'b1, 16'h0000);
		send_event(OP_EDGE,     1'b1, 16'h0001);
		send_event(OP_EDGE,     1'b0, 16'hFFFE);
	endtask

	// Register extremes: a zero span and zero rate, the widest legal span with
	// the smallest rate, and a one-tick span where the quotient lands exactly
	// on its ceiling without saturating.
	task automatic test_config_extremes();
		configure(32'd0, 32'd0);
		send_event(OP_EDGE,     1'b0, 16'd10);
		send_event(OP_OVERFLOW, 1'b0, 16'd0);
		send_event(OP_EDGE,     1'b0, 16'd5);
		send_event(OP_EDGE,     1'b0, 16'd7);
		configure(32'd65536, 32'd1);
		send_event(OP_OVERFLOW, 1'b1, 16'd0);
		send_event(OP_EDGE,     1'b1, 16'd0);
		send_event(OP_OVERFLOW, 1'b0, 16'd0);
		send_event(OP_EDGE,     1'b1, 16'd0);
		// Channel 0 sits at capture 7 with two overflows, so this is one tick.
		configure(32'd1, 32'd1000000);
		send_event(OP_EDGE,     1'b0, 16'd6);
	endtask

	// Clipping: the full 17-bit span pushes the period past 24 bits, the full
	// 20-bit rate pushes the quotient past its ceiling, and a long silence pins
	// one channel's overflow count while the other stops one short of it.
	task automatic test_overflow_saturation();
		configure(32'h1FFFF, 32'hFFFFF);
		send_event(OP_EDGE, 1'b0, 16'd0);
		repeat (130) send_event(OP_OVERFLOW, $urandom_range(1), $urandom_range(16'hFFFF));
		send_event(OP_EDGE, 1'b0, 16'd0);
		send_event(OP_EDGE, 1'b0, 16'd1);
		configure(32'd10, 32'hFFFFF);
		send_event(OP_EDGE, 1'b0, 16'd0);
		send_event(OP_EDGE, 1'b1, 16'd5);
		repeat (254) send_event(OP_OVERFLOW, $urandom_range(1), $urandom_range(16'hFFFF));
		send_event(OP_EDGE, 1'b0, 16'd7);
		send_event(OP_OVERFLOW, 1'b0, 16'd0);
		send_event(OP_OVERFLOW, 1'b1, 16'd0);
		send_event(OP_EDGE, 1'b1, 16'd3);
		send_event(OP_EDGE, 1'b0, 16'd8);
	endtask

	task automatic test_random_traffic();
		configure(32'(SPAN_RESET), 32'(RATE_RESET));
		drive_wheel_traffic(210);

		// Halfway through, the sender waits for every measurement to drain.
		configure(32'd1000, 32'd1000000);
		drive_wheel_traffic(105);
		settle_block();
		drive_wheel_traffic(105);

		// A stretch where neither side ever holds off.
		configure(32'd65536, $urandom_range(1000000, 1));
		idle_pct = 0;
		drive_wheel_traffic(210);
		idle_pct = 30;

		configure($urandom_range(65536, 1), $urandom_range(1000000, 1));
		drive_wheel_traffic(210);

		// A short span: many overflows per period and a flat rate.
		configure(32'd7, 32'd1);
		drive_wheel_traffic(210);

		configure($urandom_range(65536, 1), $urandom_range(1000000, 1));
		drive_wheel_traffic(210);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_defaults();
		test_directed_events();
		test_config_extremes();
		test_overflow_saturation();
		test_random_traffic();
		settle_block();
		$display("Sent %0d events, checked %0d measurements, %0d register writes.",
			events_sent, speeds_checked, reg_writes);
		$display("Covered first edges, zero and backward periods, clipping, and %s",
			"overflow count saturation over default, extreme and random settings.");
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches in total.", mismatches);
			$display("FAIL");
		end
		$finish;
	end

endmodule
